[hdl/hrl_pkg.sv]
// Shared types and constants of the rainbow LED frame core.
// No dependencies; every other file in hdl/ except hrl_checker.sv uses this package.
package hrl_pkg;

	localparam int NUM_LEDS_DEF = 16;

	// Queue depths: the result queue also sets the number of issue credits.
	localparam int IN_DEPTH  = 2;
	localparam int IN_AW     = $clog2(IN_DEPTH);
	localparam int OUT_DEPTH = 16;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATION  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_LEVEL = 8'd2;

	localparam logic [9:0] BRIGHTNESS_RST  = 10'd256;
	localparam logic [7:0] SATURATION_RST  = 8'd255;
	localparam logic [7:0] VALUE_LEVEL_RST = 8'd255;

	// Hue sectors, named by the color span they cover
	localparam logic [2:0] SEC_RY = 3'd0;
	localparam logic [2:0] SEC_YG = 3'd1;
	localparam logic [2:0] SEC_GC = 3'd2;
	localparam logic [2:0] SEC_CB = 3'd3;
	localparam logic [2:0] SEC_BM = 3'd4;
	localparam logic [2:0] SEC_MR = 3'd5;

	typedef struct packed {
		logic [9:0] brightness;
		logic [7:0] saturation;
		logic [7:0] value_level;
	} cfg_t;

	typedef struct packed {
		logic        vld;
		logic [15:0] hue;
	} frame_req_t;

	typedef struct packed {
		logic [3:0] led_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} res_data_t;

	typedef struct packed {
		logic      vld;
		res_data_t data;
	} res_beat_t;

endpackage

[hdl/hrl_in_queue.sv]
// Front end: small queue of accepted hue phases waiting for the color pipeline.
// Depends on hrl_pkg.
module hrl_in_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [15:0]         hue_phase,
	output logic                full,
	output hrl_pkg::frame_req_t req,
	input  logic                req_pop
);

	localparam int CW = $clog2(hrl_pkg::IN_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(hrl_pkg::IN_DEPTH);

	logic [15:0]                 mem_q [hrl_pkg::IN_DEPTH];
	logic [hrl_pkg::IN_AW-1:0]   wr_q;
	logic [hrl_pkg::IN_AW-1:0]   rd_q;
	logic [CW-1:0]               cnt_q;
	logic                        wr_en;
	logic                        rd_en;

	assign full    = (cnt_q == DEPTH_C);
	assign wr_en   = push && !full;
	assign rd_en   = req_pop && (cnt_q != '0);
	assign req.vld = (cnt_q != '0);
	assign req.hue = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= hue_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= rd_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hdl/hrl_back.sv]
// Back end: walks the LEDs of each frame and runs the eight-stage HSV-to-RGB
// and brightness pipeline. Depends on hrl_pkg.
module hrl_back #(
	parameter int NUM_LEDS = hrl_pkg::NUM_LEDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hrl_pkg::frame_req_t req,
	output logic                req_pop,
	input  hrl_pkg::cfg_t       cfg,
	input  logic                res_pop,
	output hrl_pkg::res_beat_t  res
);

	localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int RW    = $clog2(NUM_LEDS + 1) + 1;
	localparam int UW    = $clog2(hrl_pkg::OUT_DEPTH + 1);
	localparam logic [16:0]      STEP_Q   = 17'(65536 / NUM_LEDS);
	localparam logic [RW-1:0]    STEP_R   = RW'(65536 % NUM_LEDS);
	localparam logic [RW-1:0]    LEDS_N   = RW'(NUM_LEDS);
	localparam logic [LED_W-1:0] LED_LAST = LED_W'(NUM_LEDS - 1);
	localparam logic [UW-1:0]    CREDITS  = UW'(hrl_pkg::OUT_DEPTH);
	localparam logic [23:0]      FULL     = 24'd16711680;

	// x/255 for x up to 65025: reciprocal estimate, then one correction
	function automatic logic [7:0] div255_est(input logic [15:0] x);
		logic [23:0] m;
		m = {x, 8'b0} + {8'b0, x};
		return m[23:16];
	endfunction

	function automatic logic [7:0] div255_fix(input logic [15:0] x, input logic [7:0] e);
		logic [15:0] prod;
		logic [15:0] rem;
		prod = {e, 8'b0} - {8'b0, e};
		rem  = x - prod;
		return (rem >= 16'd255) ? e + 8'd1 : e;
	endfunction

	function automatic logic [7:0] scale(input logic [7:0] c, input logic [9:0] b);
		logic [17:0] m;
		m = {10'b0, c} * {8'b0, b};
		return (m[17:16] != 2'b0) ? 8'd255 : m[15:8];
	endfunction

	logic [LED_W-1:0] led_q;
	logic [15:0]      off_q;
	logic [RW-1:0]    rem_q;
	logic [UW-1:0]    used_q;
	logic             issue;
	logic             frame_end;
	logic [RW-1:0]    rem_sum;
	logic [LED_W+3:0] led_ext;

	assign issue     = req.vld && (used_q < CREDITS);
	assign frame_end = (led_q == LED_LAST);
	assign req_pop   = issue && frame_end;
	assign rem_sum   = rem_q + STEP_R;
	assign led_ext   = {4'b0, led_q};

	// LED sequencer: offset i*65536/N tracked as quotient and remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q <= '0;
			off_q <= '0;
			rem_q <= '0;
		end else if (issue) begin
			if (frame_end) begin
				led_q <= '0;
				off_q <= '0;
				rem_q <= '0;
			end else begin
				led_q <= led_q + 1'b1;
				if (rem_sum >= LEDS_N) begin
					off_q <= off_q + STEP_Q[15:0] + 16'd1;
					rem_q <= rem_sum - LEDS_N;
				end else begin
					off_q <= off_q + STEP_Q[15:0];
					rem_q <= rem_sum;
				end
			end
		end
	end

	// Credits: issued beats not yet popped from the result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (issue && !res_pop) begin
			used_q <= used_q + 1'b1;
		end else if (res_pop && !issue) begin
			used_q <= used_q - 1'b1;
		end
	end

	logic [7:0] v_q;

	logic [15:0] h_s1;
	logic [2:0]  sec_s2, sec_s3, sec_s4, sec_s5, sec_s6;
	logic [15:0] f_s2;
	logic [23:0] fs_s3, gs_s3;
	logic [15:0] pn_s3;
	logic [15:0] xq_s4, xt_s4, xp_s4;
	logic [15:0] xq_s5, xt_s5, xp_s5;
	logic [7:0]  eq_s5, et_s5, ep_s5;
	logic [7:0]  q_s6, t_s6, p_s6;
	logic [7:0]  r_s7, g_s7, b_s7;
	logic [3:0]  idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6, idx_s7, idx_s8;
	logic [7:0]  last_q;
	logic [7:0]  r_s8, g_s8, b_s8;

	logic [18:0] h6;
	logic [16:0] gf;
	logic [23:0] fs, gs;
	logic [15:0] pn;
	logic [31:0] yq, yt;
	logic [7:0]  r_sel, g_sel, b_sel;

	assign h6 = {1'b0, h_s1, 2'b0} + {2'b0, h_s1, 1'b0};
	assign gf = 17'h10000 - {1'b0, f_s2};
	assign fs = {8'b0, f_s2} * {16'b0, cfg.saturation};
	assign gs = {7'b0, gf} * {16'b0, cfg.saturation};
	assign pn = {8'b0, cfg.value_level} * {8'b0, 8'd255 - cfg.saturation};
	assign yq = {24'b0, cfg.value_level} * {8'b0, FULL - fs_s3};
	assign yt = {24'b0, cfg.value_level} * {8'b0, FULL - gs_s3};

	always_comb begin
		unique case (sec_s6)
			hrl_pkg::SEC_RY: begin
				r_sel = cfg.value_level; g_sel = t_s6; b_sel = p_s6;
			end
			hrl_pkg::SEC_YG: begin
				r_sel = q_s6; g_sel = cfg.value_level; b_sel = p_s6;
			end
			hrl_pkg::SEC_GC: begin
				r_sel = p_s6; g_sel = cfg.value_level; b_sel = t_s6;
			end
			hrl_pkg::SEC_CB: begin
				r_sel = p_s6; g_sel = q_s6; b_sel = cfg.value_level;
			end
			hrl_pkg::SEC_BM: begin
				r_sel = t_s6; g_sel = p_s6; b_sel = cfg.value_level;
			end
			default: begin
				r_sel = cfg.value_level; g_sel = p_s6; b_sel = q_s6;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[6:0], issue};
		end
	end

	always_ff @(posedge clk) begin
		h_s1    <= req.hue + off_q;
		idx_s1  <= led_ext[3:0];
		last_q  <= {last_q[6:0], frame_end};

		sec_s2 <= h6[18:16];
		f_s2   <= h6[15:0];
		idx_s2 <= idx_s1;

		fs_s3  <= fs;
		gs_s3  <= gs;
		pn_s3  <= pn;
		sec_s3 <= sec_s2;
		idx_s3 <= idx_s2;

		xq_s4  <= yq[31:16];
		xt_s4  <= yt[31:16];
		xp_s4  <= pn_s3;
		sec_s4 <= sec_s3;
		idx_s4 <= idx_s3;

		xq_s5  <= xq_s4;
		xt_s5  <= xt_s4;
		xp_s5  <= xp_s4;
		eq_s5  <= div255_est(xq_s4);
		et_s5  <= div255_est(xt_s4);
		ep_s5  <= div255_est(xp_s4);
		sec_s5 <= sec_s4;
		idx_s5 <= idx_s4;

		q_s6   <= div255_fix(xq_s5, eq_s5);
		t_s6   <= div255_fix(xt_s5, et_s5);
		p_s6   <= div255_fix(xp_s5, ep_s5);
		sec_s6 <= sec_s5;
		idx_s6 <= idx_s5;

		r_s7   <= r_sel;
		g_s7   <= g_sel;
		b_s7   <= b_sel;
		idx_s7 <= idx_s6;

		r_s8   <= scale(r_s7, cfg.brightness);
		g_s8   <= scale(g_s7, cfg.brightness);
		b_s8   <= scale(b_s7, cfg.brightness);
		idx_s8 <= idx_s7;
	end

	assign res.vld            = v_q[7];
	assign res.data.led_index = idx_s8;
	assign res.data.red       = r_s8;
	assign res.data.green     = g_s8;
	assign res.data.blue      = b_s8;
	assign res.data.last      = last_q[7];

endmodule

[hdl/hrl_res_queue.sv]
// Result queue between the color pipeline and the output ports.
// Depends on hrl_pkg; never overflows since the back end issues on credits.
module hrl_res_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  hrl_pkg::res_beat_t res,
	input  logic               pop,
	output logic               empty,
	output hrl_pkg::res_data_t head
);

	localparam int CW = $clog2(hrl_pkg::OUT_DEPTH + 1);

	hrl_pkg::res_data_t          mem_q [hrl_pkg::OUT_DEPTH];
	logic [hrl_pkg::OUT_AW-1:0]  wr_q;
	logic [hrl_pkg::OUT_AW-1:0]  rd_q;
	logic [CW-1:0]               cnt_q;
	logic                        rd_en;

	assign empty = (cnt_q == '0);
	assign rd_en = pop && !empty;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (res.vld) begin
			mem_q[wr_q] <= res.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (res.vld) begin
				wr_q <= wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= rd_q + 1'b1;
			end
			if (res.vld && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !res.vld) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hdl/hue_rainbow_led_frame_core.sv]
// Path: input queue, color pipeline, result queue; a result shows when empty goes low.
// Throughput: one result per cycle while a hue waits and credits remain, set by the
// single color pipeline that handles one LED per cycle; frames follow back to back.
// Reset: arst_n clears all queues and sequencing at once and loads brightness 256,
// saturation 255 and value level 255.
module hue_rainbow_led_frame_core #(
	parameter int NUM_LEDS = hrl_pkg::NUM_LEDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [15:0]                    hue_phase,
	input  logic                           pop,
	output logic                           empty,
	output logic [3:0]                     led_index,
	output logic [7:0]                     red,
	output logic [7:0]                     green,
	output logic [7:0]                     blue,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hrl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hrl_pkg::CFG_DATA_W-1:0] cfg_data
);

	hrl_pkg::cfg_t       cfg_q;
	hrl_pkg::frame_req_t req;
	hrl_pkg::res_beat_t  res;
	hrl_pkg::res_data_t  head;
	logic                req_pop;
	logic                res_pop;

	assign cfg_ready = 1'b1;
	assign res_pop   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness  <= hrl_pkg::BRIGHTNESS_RST;
			cfg_q.saturation  <= hrl_pkg::SATURATION_RST;
			cfg_q.value_level <= hrl_pkg::VALUE_LEVEL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hrl_pkg::REG_BRIGHTNESS:  cfg_q.brightness  <= cfg_data[9:0];
				hrl_pkg::REG_SATURATION:  cfg_q.saturation  <= cfg_data[7:0];
				hrl_pkg::REG_VALUE_LEVEL: cfg_q.value_level <= cfg_data[7:0];
				default: ; // drop writes to unknown registers
			endcase
		end
	end

	hrl_in_queue u_in_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.hue_phase (hue_phase),
		.full      (full),
		.req       (req),
		.req_pop   (req_pop)
	);

	hrl_back #(
		.NUM_LEDS (NUM_LEDS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.req_pop (req_pop),
		.cfg     (cfg_q),
		.res_pop (res_pop),
		.res     (res)
	);

	hrl_res_queue u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.pop    (pop),
		.empty  (empty),
		.head   (head)
	);

	assign led_index = head.led_index;
	assign red       = head.red;
	assign green     = head.green;
	assign blue      = head.blue;
	assign last      = head.last;

endmodule

[hdl/hrl_checker.sv]
// Port-level checks on the result stream of hue_rainbow_led_frame_core.
// Depends on the top level's ports only; bound below.
module hrl_checker #(
	parameter int NUM_LEDS = 16
) (
	input logic       clk,
	input logic       arst_n,
	input logic       pop,
	input logic       empty,
	input logic [3:0] led_index,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       last
);

	localparam logic [3:0] LAST_IDX = 4'((NUM_LEDS - 1) % 16);

	logic [3:0] exp_idx_q;

	// Track the index the next result beat must carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (pop && !empty) begin
			exp_idx_q <= last ? 4'd0 : led_index + 4'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(led_index) && $stable(red)
			&& $stable(green) && $stable(blue) && $stable(last)))
		else $error("result beat changed while stalled");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (led_index == exp_idx_q))
		else $error("LED index out of sequence");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> (led_index == LAST_IDX))
		else $error("last flag on wrong LED");

endmodule

bind hue_rainbow_led_frame_core hrl_checker #(.NUM_LEDS(NUM_LEDS)) u_hrl_checker (.*);
